>>> design/rau_pkg.sv
// Shared types, codes and widths of the running aggregate unit.
package rau_pkg;

    // Fixed field widths
    localparam int FIELD_W       = 32;
    localparam int COUNT_W       = 32;
    localparam int TOTAL_W       = 64;
    localparam int DIV_STEP_BITS = 2;

    // Stream and configuration port widths
    localparam int IN_DATA_W   = 2 * FIELD_W;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 2 * FIELD_W;
    localparam int OUT_USER_W  = 2;
    localparam int KIND_W      = 3;
    localparam int CFG_DATA_W  = 3;
    localparam int CFG_INDEX_W = 1;

    // Operation codes on the input tuser
    localparam logic [IN_USER_W-1:0] OPCODE_ADD    = 2'd0;
    localparam logic [IN_USER_W-1:0] OPCODE_DELETE = 2'd1;
    localparam logic [IN_USER_W-1:0] OPCODE_MODIFY = 2'd2;

    // Aggregate kinds
    localparam logic [KIND_W-1:0] AGG_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] AGG_MEAN    = 3'd1;
    localparam logic [KIND_W-1:0] AGG_MIN     = 3'd2;
    localparam logic [KIND_W-1:0] AGG_MAX     = 3'd3;
    localparam logic [KIND_W-1:0] AGG_SUM     = 3'd4;
    localparam logic [KIND_W-1:0] AGG_LIVE    = 3'd5;
    localparam logic [KIND_W-1:0] AGG_ADDED   = 3'd6;
    localparam logic [KIND_W-1:0] AGG_DELETED = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_KIND   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_STICKY = 1'b1;

    // Event class decided by the front end
    typedef enum logic [1:0] {
        EV_ADD,
        EV_DELETE,
        EV_MODIFY,
        EV_BAD
    } t_event;

    // Classified request held in the queue
    typedef struct packed {
        t_event             ev;
        logic [FIELD_W-1:0] new_value;
        logic [FIELD_W-1:0] prior_value;
    } t_item;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] dividend;
        logic [COUNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [TOTAL_W-1:0] quotient;
        logic [COUNT_W-1:0] remainder;
    } t_div_rsp;

endpackage

>>> design/rau_front.sv
// Input stage: accepts requests and classifies the operation.
module rau_front
    import rau_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [IN_DATA_W-1:0] i_in_data,
    input  logic [IN_USER_W-1:0] i_in_user,
    output logic                 o_push,
    output t_item                o_item,
    input  logic                 i_full
);

    logic   r_valid;
    t_item  r_item;
    t_item  dec_item;
    logic   accept;

    // Take a request when the holding register is free or drains this cycle
    assign o_in_ready = !r_valid || !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_valid && !i_full;
    assign o_item     = r_item;

    // Classify the operation code
    always_comb begin
        dec_item.new_value   = i_in_data[FIELD_W-1:0];
        dec_item.prior_value = i_in_data[IN_DATA_W-1:FIELD_W];
        case (i_in_user)
            OPCODE_ADD:    dec_item.ev = EV_ADD;
            OPCODE_DELETE: dec_item.ev = EV_DELETE;
            OPCODE_MODIFY: dec_item.ev = EV_MODIFY;
            default:       dec_item.ev = EV_BAD;
        endcase
    end

    // Hold the classified request until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && i_full);
        end
        if (accept) begin
            r_item <= dec_item;
        end
    end

endmodule

>>> design/rau_queue.sv
// Short queue of classified requests between the front and back ends.
module rau_queue
    import rau_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> design/rau_divider.sv
// Iterative restoring divider: 64-bit total over a 32-bit record count.
module rau_divider
    import rau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int ITER   = TOTAL_W / DIV_STEP_BITS;
    localparam int ITER_W = $clog2(ITER);

    logic               r_busy;
    logic               r_done;
    logic [ITER_W-1:0]  r_iter;
    logic [COUNT_W-1:0] r_rem;
    logic [TOTAL_W-1:0] r_quo;
    logic [COUNT_W-1:0] r_div;

    logic [COUNT_W-1:0] step_rem;
    logic [TOTAL_W-1:0] step_quo;
    logic [COUNT_W:0]   step_trial;

    // Retire DIV_STEP_BITS quotient bits per cycle while busy
    always_comb begin
        step_rem   = r_rem;
        step_quo   = r_quo;
        step_trial = '0;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            step_trial = {step_rem, step_quo[TOTAL_W-1]};
            step_quo   = {step_quo[TOTAL_W-2:0], 1'b0};
            if (step_trial >= {1'b0, r_div}) begin
                step_rem    = COUNT_W'(step_trial - {1'b0, r_div});
                step_quo[0] = 1'b1;
            end else begin
                step_rem = step_trial[COUNT_W-1:0];
            end
        end
    end

    // Load on start, iterate while busy, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (r_busy) begin
            r_iter <= r_iter + ITER_W'(1);
            if (r_iter == ITER_W'(ITER - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= step_quo;
            r_rem <= step_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

>>> design/rau_back.sv
// Execution stage: aggregate state, total rebuild, event rules and result register.
module rau_back
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_q_empty,
    input  t_item                  i_q_item,
    output logic                   o_q_pop,
    output t_div_req               o_div_req,
    input  t_div_rsp               i_div_rsp,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_DATA_W-1:0]  o_out_data,
    output logic [OUT_USER_W-1:0]  o_out_user
);

    localparam int W = VALUE_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_EXEC,
        S_DIV
    } t_state;

    t_state              r_state,     n_state;
    t_item               r_item,      n_item;
    logic [TOTAL_W-1:0]  r_total,     n_total;
    logic [TOTAL_W-1:0]  r_prod,      n_prod;
    logic [W-1:0]        r_agg,       n_agg;
    logic [W-1:0]        r_rem,       n_rem;
    logic [COUNT_W-1:0]  r_count,     n_count;
    logic                r_rescan,    n_rescan;
    logic [KIND_W-1:0]   r_kind;
    logic                r_sticky;
    logic                r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [OUT_USER_W-1:0] r_out_user, n_out_user;

    logic [TOTAL_W-1:0]  agg_ext;
    logic [TOTAL_W-1:0]  rem_ext;
    logic [TOTAL_W-1:0]  nv_raw;
    logic [TOTAL_W-1:0]  pv_raw;
    logic [W-1:0]        nv_w;
    logic [W-1:0]        pv_w;
    logic [TOTAL_W-1:0]  nv_e;
    logic [TOTAL_W-1:0]  pv_e;
    logic [COUNT_W-1:0]  mul_a;
    logic [TOTAL_W-1:0]  mul_p;
    logic [TOTAL_W-1:0]  mod_sum;
    logic [COUNT_W-1:0]  count_inc;
    logic [COUNT_W-1:0]  count_dec;
    logic [COUNT_W-1:0]  count_other;
    logic [TOTAL_W-1:0]  count_other_ext;
    logic [TOTAL_W-1:0]  div_rem_ext;
    logic [W-1:0]        gone_w;
    logic                is_mean;
    logic                is_min;
    logic                is_max;
    logic                beats_nv;
    logic                past_gone;
    logic                out_free;
    logic                commit;
    logic                err;
    logic [TOTAL_W-1:0]  out_agg_ext;
    logic [TOTAL_W-1:0]  out_rem_ext;

    // Operand views at the configured value width
    assign agg_ext     = TOTAL_W'(r_agg);
    assign rem_ext     = TOTAL_W'(r_rem);
    assign nv_raw      = TOTAL_W'(r_item.new_value);
    assign pv_raw      = TOTAL_W'(r_item.prior_value);
    assign nv_w        = nv_raw[W-1:0];
    assign pv_w        = pv_raw[W-1:0];
    assign nv_e        = TOTAL_W'(nv_w);
    assign pv_e        = TOTAL_W'(pv_w);
    assign div_rem_ext = TOTAL_W'(i_div_rsp.remainder);

    // One 32x32 multiplier, low half of the value first
    assign mul_a = (r_state == S_MUL_LO) ? agg_ext[COUNT_W-1:0]
                                         : agg_ext[TOTAL_W-1:COUNT_W];
    assign mul_p = mul_a * r_count;

    assign is_mean   = (r_kind == AGG_MEAN);
    assign is_min    = (r_kind == AGG_MIN);
    assign is_max    = (r_kind == AGG_MAX);
    assign mod_sum   = r_total + nv_e;
    assign count_inc = r_count + COUNT_W'(1);
    assign count_dec = r_count - COUNT_W'(1);
    assign count_other = (r_item.ev == EV_ADD)    ? count_inc :
                         (r_item.ev == EV_DELETE) ? count_dec : r_count;
    assign count_other_ext = TOTAL_W'(count_other);
    assign gone_w    = (r_item.ev == EV_DELETE) ? nv_w : pv_w;
    assign beats_nv  = is_min ? (nv_w < r_agg) : (nv_w > r_agg);
    assign past_gone = is_min ? (gone_w < r_agg) : (gone_w > r_agg);
    assign out_free  = !r_out_valid || i_out_ready;

    // Sequence one request: rebuild the total, apply the event, publish the result
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_total     = r_total;
        n_prod      = r_prod;
        n_agg       = r_agg;
        n_rem       = r_rem;
        n_count     = r_count;
        n_rescan    = r_rescan;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        o_q_pop     = 1'b0;
        o_div_req   = '0;
        commit      = 1'b0;
        err         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                n_prod  = mul_p;
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_total = r_prod + rem_ext;
                n_prod  = mul_p;
                n_state = S_SUM;
            end
            S_SUM: begin
                n_total = r_total + {r_prod[COUNT_W-1:0], {COUNT_W{1'b0}}};
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                    if (r_item.ev == EV_BAD) begin
                        err = 1'b1;
                    end else if (r_item.ev == EV_ADD && r_count == '1) begin
                        err = 1'b1;
                    end else if (r_item.ev != EV_ADD && r_count == '0) begin
                        err = 1'b1;
                    end else if (is_mean) begin
                        if (r_item.ev == EV_ADD) begin
                            n_count            = count_inc;
                            o_div_req.start    = 1'b1;
                            o_div_req.dividend = r_total + nv_e;
                            o_div_req.divisor  = count_inc;
                        end else if (r_item.ev == EV_DELETE) begin
                            if (r_sticky) begin
                                n_count = r_count;
                            end else if (nv_e > r_total) begin
                                err = 1'b1;
                            end else begin
                                n_count = count_dec;
                                if (count_dec == '0) begin
                                    n_agg    = '0;
                                    n_rem    = '0;
                                    n_rescan = 1'b0;
                                end else begin
                                    o_div_req.start    = 1'b1;
                                    o_div_req.dividend = r_total - nv_e;
                                    o_div_req.divisor  = count_dec;
                                end
                            end
                        end else begin
                            if (pv_e > mod_sum) begin
                                err = 1'b1;
                            end else begin
                                o_div_req.start    = 1'b1;
                                o_div_req.dividend = mod_sum - pv_e;
                                o_div_req.divisor  = r_count;
                            end
                        end
                        // A division finishes the request later
                        if (o_div_req.start) begin
                            commit  = 1'b0;
                            n_state = S_DIV;
                        end
                    end else if (is_min || is_max) begin
                        if (r_item.ev == EV_ADD) begin
                            if (r_count == '0 || beats_nv) begin
                                n_agg = nv_w;
                            end
                            n_count = count_inc;
                        end else if (past_gone) begin
                            err = 1'b1;
                        end else if (r_item.ev == EV_DELETE) begin
                            n_count = count_dec;
                            if (count_dec == '0) begin
                                n_agg    = '0;
                                n_rem    = '0;
                                n_rescan = 1'b0;
                            end else if (gone_w == r_agg) begin
                                n_rescan = 1'b1;
                            end
                        end else if (beats_nv) begin
                            n_agg = nv_w;
                        end else if (gone_w == r_agg && nv_w != gone_w) begin
                            n_rescan = 1'b1;
                        end
                    end else begin
                        n_count = count_other;
                        case (r_kind)
                            AGG_NONE: begin
                                n_agg = r_agg;
                            end
                            AGG_SUM: begin
                                if (r_item.ev == EV_ADD) begin
                                    n_agg = r_agg + nv_w;
                                end else if (r_item.ev == EV_DELETE) begin
                                    n_agg = r_agg - nv_w;
                                end else begin
                                    n_agg = r_agg + nv_w - pv_w;
                                end
                            end
                            AGG_LIVE: begin
                                n_agg = count_other_ext[W-1:0];
                            end
                            AGG_ADDED: begin
                                if (r_item.ev == EV_ADD && r_agg != '1) begin
                                    n_agg = r_agg + W'(1);
                                end
                            end
                            AGG_DELETED: begin
                                if (r_item.ev == EV_DELETE && r_agg != '1) begin
                                    n_agg = r_agg + W'(1);
                                end
                            end
                            default: begin
                                n_agg = r_agg;
                            end
                        endcase
                    end
                end
            end
            S_DIV: begin
                if (i_div_rsp.done && out_free) begin
                    n_agg   = i_div_rsp.quotient[W-1:0];
                    n_rem   = div_rem_ext[W-1:0];
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result register
        out_agg_ext = TOTAL_W'(n_agg);
        out_rem_ext = TOTAL_W'(n_rem);
        if (commit) begin
            n_out_valid = 1'b1;
            n_out_data  = {is_mean ? out_rem_ext[FIELD_W-1:0] : {FIELD_W{1'b0}},
                           out_agg_ext[FIELD_W-1:0]};
            n_out_user  = {err, n_rescan};
        end
    end

    // Hold state, configuration and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_agg       <= '0;
            r_rem       <= '0;
            r_count     <= '0;
            r_rescan    <= 1'b0;
            r_kind      <= AGG_NONE;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_agg       <= n_agg;
            r_rem       <= n_rem;
            r_count     <= n_count;
            r_rescan    <= n_rescan;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_index == CFG_IDX_KIND) begin
                r_kind <= i_cfg_wdata[KIND_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_IDX_STICKY) begin
                r_sticky <= i_cfg_wdata[0];
            end
        end
        r_item     <= n_item;
        r_total    <= n_total;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

>>> design/running_aggregate_unit.sv
// Running aggregate unit: one result per request, add, delete, modify or invalid.
// Each request passes the front holding register, the queue, then the back-end steps pop,
// two multiply steps, sum and execute. In mean mode execute starts the 2-bit-per-cycle
// divider (load plus 32 steps over the 64-bit total) and the result waits for it. The back
// end takes one request at a time; a stalled result holds the back end until it is taken.
// Reset (synchronous, active low) clears the aggregate, remainder, count, flag and config.
module running_aggregate_unit
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // new_value, prior_value
    input  logic [IN_USER_W-1:0]   s_axis_tuser,   // operation
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // result_value, mean_remainder
    output logic [OUT_USER_W-1:0]  m_axis_tuser,   // recompute_needed, event_error
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic     push;
    logic     full;
    logic     pop;
    logic     empty;
    t_item    front_item;
    t_item    queue_item;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // Accept and classify
    rau_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_data  (s_axis_tdata),
        .i_in_user  (s_axis_tuser),
        .o_push     (push),
        .o_item     (front_item),
        .i_full     (full)
    );

    // Decouple front and back
    rau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (empty)
    );

    // Mean division
    rau_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Execute events and publish results
    rau_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (empty),
        .i_q_item    (queue_item),
        .o_q_pop     (pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

>>> tb/sv/running_aggregate_unit_tb.sv
// Self-checking testbench of the running aggregate unit: directed table, then random phases.
module running_aggregate_unit_tb;
    import rau_pkg::*;

    // Watchdog limit for a worst case of about 870 requests
    localparam int unsigned CYCLE_LIMIT = 600_000;
    localparam int unsigned PHASES      = 16;
    localparam int unsigned PHASE_ITEMS = 53;
    localparam int unsigned TAIL_CYCLES = 60;

    // The one operation code that the unit must reject
    localparam logic [IN_USER_W-1:0] OP_INVALID = 2'd3;

    typedef logic [FIELD_W-1:0] t_word;

    typedef struct packed {
        t_word value;
        t_word remainder;
        logic  recompute;
        logic  error;
    } t_aggregate_result;

    // One row of the directed table: a register setting or a request
    typedef struct packed {
        logic                   is_setting;
        logic [KIND_W-1:0]      kind;
        logic [CFG_DATA_W-1:0]  sticky_bits;
        logic [IN_USER_W-1:0]   op;
        t_word                  new_value;
        t_word                  prior_value;
        logic                   known;
        t_aggregate_result      want;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;   // new_value, prior_value
    logic [IN_USER_W-1:0]   s_axis_tuser  = '0;   // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;         // result_value, mean_remainder
    logic [OUT_USER_W-1:0]  m_axis_tuser;         // recompute_needed, event_error
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;

    // Shadow of the unit's state and registers
    t_word             held_value;
    t_word             held_remainder;
    t_word             live_count;
    logic              rescan_flag;
    logic [KIND_W-1:0] agg_kind;
    logic              sticky;

    t_aggregate_result pending_aggregates[$];
    t_row              stimulus_table[$];
    int unsigned       fail_count   = 0;
    int unsigned       result_count = 0;
    int unsigned       cycle_count  = 0;
    logic              quiet_phase  = 1'b0;

    running_aggregate_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Print one line per failure and count it
    task automatic report_failure(string msg);
        $display("[%0d] %s", cycle_count, msg);
        fail_count++;
    endtask

    // Idle length: mostly short, now and then long, none in a quiet phase
    function automatic int unsigned idle_cycles();
        if (quiet_phase) return 0;
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Store quotient and remainder of a mean total
    function automatic void set_mean(logic [TOTAL_W-1:0] total, t_word count);
        logic [TOTAL_W-1:0] divisor;
        divisor        = {32'd0, count};
        held_value     = t_word'(total / divisor);
        held_remainder = t_word'(total % divisor);
    endfunction

    // True when v would replace the held extreme in min or max mode
    function automatic logic beats_extreme(t_word v);
        return (agg_kind == AGG_MIN) ? (v < held_value) : (v > held_value);
    endfunction

    // Fold one request into the shadow state and return the result it causes
    function automatic t_aggregate_result aggregate_after_event(logic [IN_USER_W-1:0] op,
                                                                t_word nv, t_word pv);
        t_aggregate_result  res;
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] nv64;
        logic [TOTAL_W-1:0] pv64;
        t_word              gone;
        logic               err;
        total = {32'd0, held_value} * {32'd0, live_count} + {32'd0, held_remainder};
        nv64  = {32'd0, nv};
        pv64  = {32'd0, pv};
        err   = 1'b0;
        if (op == OP_INVALID) begin
            err = 1'b1;
        end else if (op == OPCODE_ADD && live_count == '1) begin
            err = 1'b1;
        end else if (op != OPCODE_ADD && live_count == '0) begin
            err = 1'b1;
        end else if (agg_kind == AGG_MEAN) begin
            if (op == OPCODE_ADD) begin
                live_count++;
                set_mean(total + nv64, live_count);
            end else if (op == OPCODE_DELETE) begin
                // sticky mean: deletes leave everything as it is
                if (!sticky) begin
                    if (nv64 > total) begin
                        err = 1'b1;
                    end else begin
                        live_count--;
                        if (live_count == '0) begin
                            held_value     = '0;
                            held_remainder = '0;
                            rescan_flag    = 1'b0;
                        end else begin
                            set_mean(total - nv64, live_count);
                        end
                    end
                end
            end else if (pv64 > total + nv64) begin
                err = 1'b1;
            end else begin
                set_mean(total + nv64 - pv64, live_count);
            end
        end else if (agg_kind == AGG_MIN || agg_kind == AGG_MAX) begin
            if (op == OPCODE_ADD) begin
                // first add after empty seeds the extreme
                if (live_count == '0 || beats_extreme(nv)) held_value = nv;
                live_count++;
            end else begin
                gone = (op == OPCODE_DELETE) ? nv : pv;
                if (beats_extreme(gone)) begin
                    err = 1'b1;
                end else if (op == OPCODE_DELETE) begin
                    live_count--;
                    if (live_count == '0) begin
                        held_value     = '0;
                        held_remainder = '0;
                        rescan_flag    = 1'b0;
                    end else if (gone == held_value) begin
                        rescan_flag = 1'b1;
                    end
                end else if (beats_extreme(nv)) begin
                    held_value = nv;
                end else if (gone == held_value && nv != gone) begin
                    rescan_flag = 1'b1;
                end
            end
        end else begin
            if (op == OPCODE_ADD) live_count++;
            else if (op == OPCODE_DELETE) live_count--;
            case (agg_kind)
                AGG_SUM: begin
                    if (op == OPCODE_ADD) held_value = held_value + nv;
                    else if (op == OPCODE_DELETE) held_value = held_value - nv;
                    else held_value = held_value + nv - pv;
                end
                AGG_LIVE: begin
                    held_value = live_count;
                end
                AGG_ADDED: begin
                    if (op == OPCODE_ADD && held_value != '1) held_value++;
                end
                AGG_DELETED: begin
                    if (op == OPCODE_DELETE && held_value != '1) held_value++;
                end
                default: begin
                end
            endcase
        end
        res.value     = held_value;
        res.remainder = (agg_kind == AGG_MEAN) ? held_remainder : '0;
        res.recompute = rescan_flag;
        res.error     = err;
        return res;
    endfunction

    // Operand biased towards the edges and the held aggregate
    function automatic t_word pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return t_word'($urandom_range(0, 15));
            4:       return held_value;
            5:       return held_value + t_word'($urandom_range(0, 2)) - 1;
            default: return $urandom;
        endcase
    endfunction

    // Table builders
    function automatic void add_setting(logic [KIND_W-1:0] kind, logic [CFG_DATA_W-1:0] sb);
        t_row r;
        r             = '0;
        r.is_setting  = 1'b1;
        r.kind        = kind;
        r.sticky_bits = sb;
        stimulus_table.push_back(r);
    endfunction

    function automatic void add_request(logic [IN_USER_W-1:0] op, t_word nv, t_word pv);
        t_row r;
        r             = '0;
        r.op          = op;
        r.new_value   = nv;
        r.prior_value = pv;
        stimulus_table.push_back(r);
    endfunction

    function automatic void add_known(logic [IN_USER_W-1:0] op, t_word nv, t_word pv,
                                      t_word value, t_word rem, logic rc, logic err);
        t_row r;
        r             = '0;
        r.op          = op;
        r.new_value   = nv;
        r.prior_value = pv;
        r.known       = 1'b1;
        r.want        = '{value, rem, rc, err};
        stimulus_table.push_back(r);
    endfunction

    // Present one request, hold it until taken, then log what it should produce
    task automatic send_request(logic [IN_USER_W-1:0] op, t_word nv, t_word pv,
                                logic known, t_aggregate_result want);
        int unsigned       gap;
        t_aggregate_result predicted;
        gap = ($urandom_range(0, 1) == 0) ? 0 : idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pv, nv};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predicted = aggregate_after_event(op, nv, pv);
        pending_aggregates.push_back(known ? want : predicted);
    endtask

    // Drain the unit, then write both registers
    task automatic write_setting(logic [KIND_W-1:0] kind, logic [CFG_DATA_W-1:0] sb);
        s_axis_tvalid <= 1'b0;
        while (pending_aggregates.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IDX_KIND;
        i_cfg_wdata <= kind;
        @(posedge i_clk);
        i_cfg_index <= CFG_IDX_STICKY;
        i_cfg_wdata <= sb;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        agg_kind = kind;
        sticky   = sb[0];
    endtask

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random back-pressure, compare each taken result with the oldest expectation
    initial begin : result_sink
        t_aggregate_result want;
        int unsigned       stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                result_count++;
                if (pending_aggregates.size() == 0) begin
                    report_failure($sformatf("result %0d arrived with none expected",
                                             result_count));
                end else begin
                    want = pending_aggregates.pop_front();
                    if (m_axis_tdata[FIELD_W-1:0] !== want.value)
                        report_failure($sformatf("result %0d value %h, want %h", result_count,
                                                 m_axis_tdata[FIELD_W-1:0], want.value));
                    if (m_axis_tdata[2*FIELD_W-1:FIELD_W] !== want.remainder)
                        report_failure($sformatf("result %0d remainder %h, want %h",
                                                 result_count,
                                                 m_axis_tdata[2*FIELD_W-1:FIELD_W],
                                                 want.remainder));
                    if (m_axis_tuser[0] !== want.recompute)
                        report_failure($sformatf("result %0d recompute %b, want %b",
                                                 result_count, m_axis_tuser[0],
                                                 want.recompute));
                    if (m_axis_tuser[1] !== want.error)
                        report_failure($sformatf("result %0d error %b, want %b",
                                                 result_count, m_axis_tuser[1], want.error));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0) stall_left = idle_cycles();
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        t_row                  r;
        logic [KIND_W-1:0]     kind;
        logic [CFG_DATA_W-1:0] sb;
        logic [IN_USER_W-1:0]  op;
        int unsigned           add_pct;
        int unsigned           roll;
        held_value     = '0;
        held_remainder = '0;
        live_count     = '0;
        rescan_flag    = 1'b0;
        agg_kind       = AGG_NONE;
        sticky         = 1'b0;

        // After reset: impossible requests on an empty unit
        add_known(OPCODE_DELETE, 32'h1234_5678, '0, '0, '0, 1'b0, 1'b1);
        add_known(OP_INVALID, '1, '1, '0, '0, 1'b0, 1'b1);
        add_known(OPCODE_MODIFY, '0, '1, '0, '0, 1'b0, 1'b1);
        // Mean: extremes, negative totals, sticky delete, emptying
        add_setting(AGG_MEAN, 3'b000);
        add_known(OPCODE_ADD, '1, '0, '1, '0, 1'b0, 1'b0);
        add_known(OPCODE_ADD, '0, '1, 32'h7FFF_FFFF, 32'd1, 1'b0, 1'b0);
        add_request(OPCODE_ADD, 32'd5, '0);
        add_request(OPCODE_DELETE, '1, '0);
        add_request(OPCODE_MODIFY, '0, '1);
        add_request(OPCODE_DELETE, '1, '0);
        add_setting(AGG_MEAN, 3'b101);
        add_request(OPCODE_DELETE, 32'd5, '0);
        add_setting(AGG_MEAN, 3'b000);
        add_request(OPCODE_DELETE, 32'd4, '0);
        add_request(OPCODE_DELETE, 32'd1, '0);
        // Min: seeding, past extreme, removing the extreme, modify that beats it
        add_setting(AGG_MIN, 3'b000);
        add_known(OPCODE_ADD, 32'd7, '0, 32'd7, '0, 1'b0, 1'b0);
        add_request(OPCODE_ADD, 32'd3, '0);
        add_known(OPCODE_DELETE, 32'd1, '0, 32'd3, '0, 1'b0, 1'b1);
        add_request(OPCODE_DELETE, 32'd3, '0);
        add_request(OPCODE_MODIFY, 32'd2, 32'd7);
        add_request(OPCODE_DELETE, 32'd2, '0);
        // Max: seed at all ones, then modify the extreme away
        add_setting(AGG_MAX, 3'b000);
        add_request(OPCODE_ADD, '1, '0);
        add_request(OPCODE_MODIFY, '0, '1);
        // Remaining kinds read the kept state
        add_setting(AGG_SUM, 3'b000);
        add_request(OPCODE_ADD, '1, '0);
        add_setting(AGG_LIVE, 3'b000);
        add_request(OPCODE_ADD, '0, '0);
        add_setting(AGG_ADDED, 3'b000);
        add_request(OPCODE_ADD, 32'd1, '0);
        add_setting(AGG_DELETED, 3'b000);
        add_request(OPCODE_DELETE, 32'd1, '0);
        add_setting(AGG_NONE, 3'b000);
        add_request(OPCODE_MODIFY, 32'd1, 32'd2);

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (stimulus_table[i]) begin
            r = stimulus_table[i];
            if (r.is_setting) write_setting(r.kind, r.sticky_bits);
            else send_request(r.op, r.new_value, r.prior_value, r.known, r.want);
        end

        // Random phases: every kind once, a sticky mean, then random settings
        for (int p = 0; p < PHASES; p++) begin
            if (p < 8) begin
                kind = KIND_W'(p);
                sb   = {2'($urandom_range(0, 3)), 1'b0};
            end else if (p == 8) begin
                kind = AGG_MEAN;
                sb   = {2'($urandom_range(0, 3)), 1'b1};
            end else begin
                kind = KIND_W'($urandom_range(0, 7));
                sb   = CFG_DATA_W'($urandom_range(0, 7));
            end
            write_setting(kind, sb);
            quiet_phase = ($urandom_range(0, 3) == 0);
            add_pct     = $urandom_range(35, 60);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) op = OP_INVALID;
                else if (roll < add_pct) op = OPCODE_ADD;
                else if (roll < add_pct + (100 - add_pct) * 3 / 5) op = OPCODE_DELETE;
                else op = OPCODE_MODIFY;
                send_request(op, pick_value(), pick_value(), 1'b0, '0);
            end
        end

        // Drain, then allow for late strays
        s_axis_tvalid <= 1'b0;
        while (pending_aggregates.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
design/rau_pkg.sv
design/rau_front.sv
design/rau_queue.sv
design/rau_divider.sv
design/rau_back.sv
design/running_aggregate_unit.sv
tb/sv/running_aggregate_unit_tb.sv
